>>> rtl/u2g_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u2g_pkg
// Shared types, constants and decode and hex helpers for the UTF-8 to GBK transcoder.
// ----------------------------------------------------------------------------
package u2g_pkg;

  localparam int MAP_DEPTH_DEF = 65536;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_INVALID_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_BYTE = 1'd1;

  localparam logic [1:0] MODE_REPLACE = 2'd0;
  localparam logic [1:0] MODE_ERROR   = 2'd1;
  localparam logic [1:0] MODE_ENTITY  = 2'd2;

  localparam logic REQ_TABLE = 1'b0;
  localparam logic REQ_BYTE  = 1'b1;

  localparam logic [7:0]  REPLACE_RESET = 8'h3F;
  localparam logic [15:0] EURO_POINT    = 16'h20AC;
  localparam logic [7:0]  GBK_EURO_BYTE = 8'h80;
  localparam logic [15:0] ASCII_LIMIT   = 16'h0080;

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_X    = 8'h78;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  typedef enum logic [1:0] {
    BK_ONE,
    BK_TWO,
    BK_ERR,
    BK_ENT
  } burst_kind_t;

  function automatic logic [2:0] seq_len(input logic [7:0] b);
    logic [2:0] len;
    if (b < 8'h80)      len = 3'd1;
    else if (b < 8'hC0) len = 3'd0;
    else if (b < 8'hE0) len = 3'd2;
    else if (b < 8'hF0) len = 3'd3;
    else if (b < 8'hF8) len = 3'd4;
    else if (b < 8'hFC) len = 3'd5;
    else if (b < 8'hFE) len = 3'd6;
    else                len = 3'd0;
    return len;
  endfunction

  function automatic logic [7:0] lead_mask(input logic [2:0] len);
    logic [7:0] m;
    case (len)
      3'd2:    m = 8'h1F;
      3'd3:    m = 8'h0F;
      3'd4:    m = 8'h07;
      3'd5:    m = 8'h03;
      3'd6:    m = 8'h01;
      default: m = 8'hFF;
    endcase
    return m;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) c = 8'h30 + {4'h0, n};
    else           c = 8'h37 + {4'h0, n};
    return c;
  endfunction

endpackage
`default_nettype wire

>>> rtl/utf8_to_gbk_transcoder_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_to_gbk_transcoder_core
// Decodes a UTF-8 word stream and emits GBK, ASCII, replacement, entity or error bytes.
// An input word passes the lookup stage, then the burst stage to the output.
// Throughput: one input word per cycle while each yields at most one byte and
//   out_tready is high; a longer result holds input (one output byte/cycle).
// The map table read (synchronous memory) sets the lookup stage.
// Reset clears decode state, configuration and valid flags; the map memory is not cleared
//   and every entry must be loaded before it is looked up.
// ----------------------------------------------------------------------------
module utf8_to_gbk_transcoder_core #(
  parameter int MAP_DEPTH = u2g_pkg::MAP_DEPTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // [15:0] table_index, [31:16] table_word, [39:32] data_byte
  input  wire logic [u2g_pkg::IN_DATA_W-1:0]    in_tdata,
  // [0] req_type
  input  wire logic                             in_tuser,
  input  wire logic                             in_tlast,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [7:0] out_byte
  output logic [u2g_pkg::OUT_DATA_W-1:0]        out_tdata,
  // [0] status
  output logic                                  out_tuser,
  output logic                                  out_tlast,
  input  wire logic                             cfg_we,
  input  wire logic [u2g_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [u2g_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import u2g_pkg::*;

  localparam int AW = $clog2(MAP_DEPTH);

  logic [1:0]  mode_r;
  logic [7:0]  replace_r;
  logic [15:0] accum_r, accum_nxt;
  logic [2:0]  bl_r, bl_nxt;
  logic        stopped_r, stopped_nxt;

  logic [15:0] mem [MAP_DEPTH];
  logic [15:0] mem_q_r;

  logic        s1_valid_r;
  logic [15:0] s1_cp_r;
  logic        s1_eot_r;
  logic        s1_inrange_r;

  logic        b_valid_r;
  burst_kind_t b_kind_r;
  logic [15:0] b_data_r;
  logic [2:0]  b_idx_r;
  logic [2:0]  b_last_r;

  logic        acc, req_char, emit, s1_adv, s1_err, b_done, out_fire;
  logic [15:0] in_idx, in_word, emit_cp, s1_word;
  logic [7:0]  in_byte;
  logic [2:0]  lead_len;
  logic        mem_we, rd_inrange;
  burst_kind_t r_kind;
  logic [15:0] r_data;
  logic [2:0]  r_last;

  assign in_idx   = in_tdata[15:0];
  assign in_word  = in_tdata[31:16];
  assign in_byte  = in_tdata[39:32];
  assign req_char = (in_tuser == REQ_BYTE);

  assign out_fire  = b_valid_r && out_tready;
  assign b_done    = out_fire && (b_idx_r == b_last_r);
  assign s1_adv    = s1_valid_r && (!b_valid_r || b_done);
  assign in_tready = !s1_valid_r || s1_adv;
  assign acc       = in_tvalid && in_tready;

  // lookup result resolution
  assign s1_word = s1_inrange_r ? mem_q_r : 16'h0000;

  always_comb begin
    r_kind = BK_ONE;
    r_data = 16'h0000;
    r_last = 3'd0;
    if (s1_cp_r < ASCII_LIMIT) begin
      r_data = s1_cp_r;
    end else if (s1_word != 16'h0000) begin
      r_kind = BK_TWO;
      r_data = s1_word;
      r_last = 3'd1;
    end else if (s1_cp_r == EURO_POINT) begin
      r_data = {8'h00, GBK_EURO_BYTE};
    end else if (mode_r == MODE_ERROR) begin
      r_kind = BK_ERR;
    end else if (mode_r == MODE_ENTITY) begin
      r_kind = BK_ENT;
      r_data = s1_cp_r;
      r_last = 3'd7;
    end else begin
      r_data = {8'h00, replace_r};
    end
  end

  assign s1_err = s1_adv && (r_kind == BK_ERR) && !s1_eot_r;

  // decode
  always_comb begin
    accum_nxt   = accum_r;
    bl_nxt      = bl_r;
    stopped_nxt = stopped_r;
    emit        = 1'b0;
    emit_cp     = 16'h0000;
    lead_len    = seq_len(in_byte);
    if (acc && req_char) begin
      if (!stopped_r) begin
        if (bl_r == 3'd0) begin
          if (lead_len == 3'd1) begin
            emit    = 1'b1;
            emit_cp = {8'h00, in_byte};
          end else if (lead_len > 3'd1) begin
            accum_nxt = {8'h00, in_byte & lead_mask(lead_len)};
            bl_nxt    = lead_len - 3'd1;
          end
        end else begin
          accum_nxt = {accum_r[9:0], in_byte[5:0]};
          bl_nxt    = bl_r - 3'd1;
          if (bl_r == 3'd1) begin
            emit    = 1'b1;
            emit_cp = accum_nxt;
          end
        end
      end
      if (in_tlast) begin
        bl_nxt      = 3'd0;
        stopped_nxt = 1'b0;
      end
    end
    // error resolved this cycle: drop the word taken alongside it
    if (s1_err) begin
      bl_nxt      = 3'd0;
      stopped_nxt = !(acc && req_char && in_tlast);
      emit        = 1'b0;
    end
  end

  assign rd_inrange = ({1'b0, emit_cp} < 17'(MAP_DEPTH));
  assign mem_we     = acc && !req_char && ({1'b0, in_idx} < 17'(MAP_DEPTH));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[in_idx[AW-1:0]] <= in_word;
    end
    if (emit) begin
      mem_q_r <= mem[emit_cp[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_REPLACE;
      replace_r <= REPLACE_RESET;
      accum_r   <= 16'h0000;
      bl_r      <= 3'd0;
      stopped_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_INVALID_MODE) begin
        mode_r <= cfg_data[1:0];
      end
      if (cfg_we && cfg_index == CFG_REPLACE_BYTE) begin
        replace_r <= cfg_data;
      end
      accum_r   <= accum_nxt;
      bl_r      <= bl_nxt;
      stopped_r <= stopped_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (emit) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      s1_cp_r      <= emit_cp;
      s1_eot_r     <= in_tlast;
      s1_inrange_r <= rd_inrange;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (s1_adv) begin
      b_valid_r <= 1'b1;
    end else if (b_done) begin
      b_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      b_kind_r <= r_kind;
      b_data_r <= r_data;
      b_last_r <= r_last;
      b_idx_r  <= 3'd0;
    end else if (out_fire) begin
      b_idx_r <= b_idx_r + 3'd1;
    end
  end

  // output byte select
  always_comb begin
    out_tdata = 8'h00;
    case (b_kind_r)
      BK_ONE: out_tdata = b_data_r[7:0];
      BK_TWO: out_tdata = (b_idx_r == 3'd0) ? b_data_r[15:8] : b_data_r[7:0];
      BK_ERR: out_tdata = 8'h00;
      BK_ENT: begin
        case (b_idx_r)
          3'd0:    out_tdata = CH_AMP;
          3'd1:    out_tdata = CH_HASH;
          3'd2:    out_tdata = CH_X;
          3'd3:    out_tdata = hex_char(b_data_r[15:12]);
          3'd4:    out_tdata = hex_char(b_data_r[11:8]);
          3'd5:    out_tdata = hex_char(b_data_r[7:4]);
          3'd6:    out_tdata = hex_char(b_data_r[3:0]);
          default: out_tdata = CH_SEMI;
        endcase
      end
      default: out_tdata = 8'h00;
    endcase
  end

  assign out_tvalid = b_valid_r;
  assign out_tuser  = (b_kind_r == BK_ERR);
  assign out_tlast  = (b_idx_r == b_last_r);

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r |-> (b_idx_r <= b_last_r))
    else $error("burst index beyond last byte");

  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tlast && out_tdata == 8'h00))
    else $error("error result not a single zero byte");

  a_stop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |-> (bl_r == 3'd0))
    else $error("sequence in progress while stopped");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_cp_r)))
    else $error("lookup stage lost while stalled");

endmodule
`default_nettype wire

>>> tb/sv/utf8_to_gbk_transcoder_core_tb.sv
// ----------------------------------------------------------------------------
// utf8_to_gbk_transcoder_core_tb
// Streams table loads and UTF-8 text into the transcoder under several
// unmappable-handling settings, with bursty input and a stalling output.
// A scoreboard decodes every accepted word and checks each output word in
// order, field by field.
// ----------------------------------------------------------------------------
module utf8_to_gbk_transcoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import u2g_pkg::*;

  localparam logic [1:0] MODE_ALT_REPLACE = 2'd3;
  localparam int unsigned IDLE_LIMIT = 1000;
  localparam int unsigned ITEMS_PER_PHASE = 12;

  typedef struct packed {
    logic [7:0] data;
    logic       status;
    logic       last;
  } gbk_byte_t;

  class gbk_scoreboard;
    logic [1:0]  mode = MODE_REPLACE;
    logic [7:0]  repl = REPLACE_RESET;
    logic [15:0] accum = '0;
    int unsigned left = 0;
    bit          stopped = 0;
    logic [15:0] map_words [logic [15:0]];
    gbk_byte_t   step_q [$];
    gbk_byte_t   gbk_expected [$];
    int unsigned errors = 0;
    int unsigned n_inputs = 0;
    int unsigned n_results = 0;
    int unsigned n_err_results = 0;
    int unsigned n_entities = 0;

    task report(string msg);
      errors++;
      if (errors <= 30) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    function int unsigned pending();
      return gbk_expected.size();
    endfunction

    function void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_INVALID_MODE) mode = data[1:0];
      else repl = data;
    endfunction

    function bit needs_entry(logic [7:0] b, output logic [15:0] cp);
      cp = {accum[9:0], b[5:0]};
      return !stopped && left == 1 && cp >= ASCII_LIMIT && !map_words.exists(cp);
    endfunction

    function int unsigned lead_len(logic [7:0] b);
      if (b < 8'h80) return 1;
      if (b < 8'hC0) return 0;
      if (b < 8'hE0) return 2;
      if (b < 8'hF0) return 3;
      if (b < 8'hF8) return 4;
      if (b < 8'hFC) return 5;
      if (b < 8'hFE) return 6;
      return 0;
    endfunction

    function logic [7:0] lead_bits(logic [7:0] b, int unsigned len);
      case (len)
        2: return b & 8'h1F;
        3: return b & 8'h0F;
        4: return b & 8'h07;
        5: return b & 8'h03;
        default: return b & 8'h01;
      endcase
    endfunction

    function logic [7:0] hex_ascii(logic [3:0] n);
      if (n < 4'd10) return 8'h30 + {4'h0, n};
      return 8'h41 + {4'h0, n} - 8'd10;
    endfunction

    function void add(logic [7:0] data, logic status);
      gbk_byte_t r;
      r.data = data;
      r.status = status;
      r.last = 1'b0;
      step_q.push_back(r);
    endfunction

    function void translate(logic [15:0] cp);
      logic [15:0] w;
      if (cp < ASCII_LIMIT) begin
        add(cp[7:0], 1'b0);
        return;
      end
      w = map_words.exists(cp) ? map_words[cp] : 16'h0000;
      if (w != 16'h0000) begin
        add(w[15:8], 1'b0);
        add(w[7:0], 1'b0);
      end else if (cp == EURO_POINT) begin
        add(GBK_EURO_BYTE, 1'b0);
      end else if (mode == MODE_ERROR) begin
        add(8'h00, 1'b1);
        stopped = 1;
        n_err_results++;
      end else if (mode == MODE_ENTITY) begin
        add(CH_AMP, 1'b0);
        add(CH_HASH, 1'b0);
        add(CH_X, 1'b0);
        add(hex_ascii(cp[15:12]), 1'b0);
        add(hex_ascii(cp[11:8]), 1'b0);
        add(hex_ascii(cp[7:4]), 1'b0);
        add(hex_ascii(cp[3:0]), 1'b0);
        add(CH_SEMI, 1'b0);
        n_entities++;
      end else begin
        add(repl, 1'b0);
      end
    endfunction

    function void note_input(logic req, logic [15:0] idx, logic [15:0] word,
                             logic [7:0] b, logic eot);
      int unsigned len;
      gbk_byte_t r;
      n_inputs++;
      if (req == REQ_TABLE) begin
        map_words[idx] = word;
        return;
      end
      step_q.delete();
      if (!stopped) begin
        if (left == 0) begin
          len = lead_len(b);
          if (len == 1) begin
            translate({8'h00, b});
          end else if (len > 1) begin
            accum = {8'h00, lead_bits(b, len)};
            left = len - 1;
          end
        end else begin
          accum = {accum[9:0], b[5:0]};
          left--;
          if (left == 0) translate(accum);
        end
      end
      if (eot) begin
        left = 0;
        stopped = 0;
      end
      for (int i = 0; i < step_q.size(); i++) begin
        r = step_q[i];
        r.last = (i == step_q.size() - 1);
        gbk_expected.push_back(r);
      end
    endfunction

    task check_result(logic [7:0] data, logic status, logic last);
      gbk_byte_t e;
      n_results++;
      if (gbk_expected.size() == 0) begin
        report($sformatf("unexpected word data=%02h status=%0b last=%0b", data, status, last));
        return;
      end
      e = gbk_expected.pop_front();
      if (data !== e.data)
        report($sformatf("word %0d: data %02h, want %02h", n_results, data, e.data));
      if (status !== e.status)
        report($sformatf("word %0d: status %0b, want %0b", n_results, status, e.status));
      if (last !== e.last)
        report($sformatf("word %0d: last %0b, want %0b", n_results, last, e.last));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  gbk_scoreboard sb = new();

  int unsigned burst_left = 0;
  bit          no_gaps = 0;
  bit          free_flow = 0;
  int unsigned item_cnt = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_cnt = 0;
  bit          stalling = 0;
  logic [15:0] cp_pool [8] = '{16'h0080, 16'h00A9, 16'h07FF, 16'h20AC,
                               16'h4E2D, 16'hFFFF, 16'h8000, 16'h3000};

  utf8_to_gbk_transcoder_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (hold_cnt != 0) begin
      hold_cnt--;
    end else begin
      stalling = !stalling;
      hold_cnt = stalling ? $urandom_range(0, 7) : $urandom_range(0, 24);
    end
    out_tready <= free_flow || !stalling;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser, out_tlast);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [15:0] pick_word();
    if ($urandom_range(0, 99) < 35) return 16'h0000;
    return 16'($urandom_range(1, 16'hFFFF));
  endfunction

  task automatic push(input logic req, input logic [15:0] idx, input logic [15:0] word,
                      input logic [7:0] b, input logic eot);
    int unsigned gap;
    if (!no_gaps && burst_left == 0) begin
      gap = $urandom_range(0, 9);
      burst_left = $urandom_range(1, 16);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left != 0) burst_left--;
    in_tdata  <= {b, word, idx};
    in_tuser  <= req;
    in_tlast  <= eot;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(req, idx, word, b, eot);
    item_cnt++;
  endtask

  task automatic load_entry(input logic [15:0] idx, input logic [15:0] word);
    push(REQ_TABLE, idx, word, 8'($urandom), 1'($urandom));
  endtask

  // load a table entry first when this word would look up an unloaded one
  task automatic push_byte(input logic [7:0] b, input logic eot);
    logic [15:0] cp;
    if (sb.needs_entry(b, cp)) load_entry(cp, pick_word());
    push(REQ_BYTE, 16'($urandom), 16'($urandom), b, eot);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.apply_cfg(idx, data);
    @(posedge clk);
  endtask

  task automatic send_char();
    int unsigned r;
    int unsigned len;
    int unsigned sent;
    logic [31:0] cp;
    logic [7:0]  hdr;
    logic [7:0]  msk;
    logic [7:0]  b;
    logic        eot;
    r = $urandom_range(0, 99);
    eot = ($urandom_range(0, 99) < 15);
    if (r < 20) begin
      push_byte(8'($urandom_range(0, 127)), eot);
    end else if (r < 30) begin
      push_byte(8'($urandom), eot);
    end else if (r < 36) begin
      if ($urandom_range(0, 1) == 0) load_entry(16'($urandom), pick_word());
      else load_entry(cp_pool[$urandom_range(0, 7)], pick_word());
    end else begin
      r = $urandom_range(0, 99);
      len = (r < 40) ? 2 : (r < 85) ? 3 : (r < 93) ? 4 : (r < 97) ? 5 : 6;
      cp = ($urandom_range(0, 1) == 0) ? {16'h0, cp_pool[$urandom_range(0, 7)]} : $urandom;
      case (len)
        2:       begin hdr = 8'hC0; msk = 8'h1F; end
        3:       begin hdr = 8'hE0; msk = 8'h0F; end
        4:       begin hdr = 8'hF0; msk = 8'h07; end
        5:       begin hdr = 8'hF8; msk = 8'h03; end
        default: begin hdr = 8'hFC; msk = 8'h01; end
      endcase
      // truncate: stop early and end the text mid-sequence
      sent = ($urandom_range(0, 99) < 8) ? $urandom_range(1, len - 1) : len;
      push_byte(hdr | (8'(cp >> (6 * (len - 1))) & msk), sent == 1 && (eot || sent < len));
      for (int k = 1; k < sent; k++) begin
        b = {2'b10, 6'(cp >> (6 * (len - 1 - k)))};
        if ($urandom_range(0, 99) < 15) b[7:6] = 2'($urandom);
        push_byte(b, (k == sent - 1) && (eot || sent < len));
      end
    end
  endtask

  initial begin
    logic [1:0] modes [6];
    logic [7:0] repls [6];
    modes = '{MODE_ENTITY, MODE_ERROR, MODE_ALT_REPLACE, MODE_REPLACE, MODE_ENTITY, MODE_ERROR};
    repls = '{8'h00, 8'hFF, 8'($urandom), 8'hFF, 8'($urandom), 8'($urandom)};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push(REQ_TABLE, 16'h4E2D, 16'hD6D0, 8'hFF, 1'b1);
    push(REQ_TABLE, EURO_POINT, 16'h0000, 8'h00, 1'b0);
    push(REQ_TABLE, 16'h00A9, 16'h0000, 8'h55, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'hE4, 1'b0);
    push_byte(8'hB8, 1'b0);
    push_byte(8'hAD, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hFE, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hE2, 1'b0);
    push_byte(8'h82, 1'b0);
    push_byte(8'hAC, 1'b0);
    push_byte(8'hC1, 1'b0);
    push_byte(8'h81, 1'b0);
    push_byte(8'hC2, 1'b0);
    push_byte(8'hA9, 1'b0);
    push_byte(8'hE4, 1'b0);
    push_byte(8'hB8, 1'b1);
    push(REQ_TABLE, EURO_POINT, 16'hA2E3, 8'h00, 1'b0);
    push_byte(8'hE2, 1'b0);
    push_byte(8'h82, 1'b0);
    push_byte(8'hAC, 1'b1);

    for (int p = 0; p < 6; p++) begin
      drain();
      set_cfg(CFG_INVALID_MODE, {6'h00, modes[p]});
      set_cfg(CFG_REPLACE_BYTE, repls[p]);
      no_gaps = (p == 2);
      free_flow = (p == 2);
      begin
        int unsigned phase_end;
        phase_end = item_cnt + ITEMS_PER_PHASE;
        while (item_cnt < phase_end) begin
          send_char();
          if ($urandom_range(0, 39) == 0) drain();
        end
      end
    end

    no_gaps = 0;
    free_flow = 0;
    drain();
    if (sb.pending() != 0) sb.report($sformatf("%0d words never arrived", sb.pending()));
    $display("run: %0d input words, %0d output words checked", sb.n_inputs, sb.n_results);
    $display("run: %0d error words, %0d entities, 6 handling settings", sb.n_err_results,
             sb.n_entities);
    if (sb.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

>>> files.f
rtl/u2g_pkg.sv
rtl/utf8_to_gbk_transcoder_core.sv
tb/sv/utf8_to_gbk_transcoder_core_tb.sv
